// File: rtl/core/fpbs_pkg.sv
// Shared constants, codes and types of the binomial-series power block.
package fpbs_pkg;

  // Number of series terms, counting the constant term.
  localparam int TERM_LIMIT = 100;
  localparam int IDX_W      = $clog2(TERM_LIMIT) + 1;

  localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
  localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;
  localparam logic [31:0] TWO_BITS     = 32'h4000_0000;
  localparam logic [31:0] ERROR_BITS   = 32'h4F80_0000;
  localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
  // Smallest single at or above 0.0001 and largest single at or below 0.999.
  localparam logic [31:0] FRAC_LO_BITS = 32'h38D1_B718;
  localparam logic [31:0] FRAC_HI_BITS = 32'h3F7F_BE76;
  // One unit of the exponent field: subtracting it halves a normal value.
  localparam logic [31:0] EXP_LSB_BITS = 32'h0080_0000;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_MUL,
    FOP_DIV
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ADD,
    F_DIVNORM,
    F_DIVSTEP,
    F_NORM,
    F_DEN,
    F_RND
  } fpu_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLASS,
    S_FRAC,
    S_CHECK,
    S_RANGE,
    S_SUB1,
    S_PW,
    S_BSUB,
    S_BADD,
    S_BMUL,
    S_BDIV,
    S_PROD,
    S_SUM,
    S_SCALE,
    S_FINAL,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_SINGLE,
    PH_FIRST,
    PH_SECOND
  } phase_t;

endpackage

// File: rtl/core/fpbs_fpu.sv
// Shared single-precision add, multiply and divide unit, round to nearest even.
module fpbs_fpu (
  input  logic               clk,
  input  logic               rst,
  input  fpbs_pkg::fpu_req_t req,
  output fpbs_pkg::fpu_rsp_t rsp
);
  import fpbs_pkg::*;

  fpu_state_t state, state_next;

  logic               sgn;
  logic signed [11:0] ex;
  logic [48:0]        mw;
  logic               stk;
  logic [48:0]        add_a, add_b;
  logic               add_sub;
  logic [23:0]        dma, dmb;
  logic [24:0]        rem;
  logic [5:0]         cnt;
  logic [31:0]        res;
  logic               done;

  // Operand decode.
  logic [7:0]  a_e8, b_e8, a_exp, b_exp;
  logic [23:0] a_man, b_man;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
  logic        spec_hit;
  logic [31:0] spec_bits;
  logic [47:0] prod;
  logic        a_big, l_sgn;
  logic [7:0]  l_exp, s_exp, dsh;
  logic [23:0] l_man, s_man;
  logic [48:0] b_full, b_mask, b_align;
  logic [48:0] add_res;
  logic [25:0] div_diff;
  logic        div_q;
  logic [24:0] div_rn;
  logic signed [11:0] den_sh;
  logic [48:0] den_mask;
  logic [23:0] rm, rmf;
  logic        rs, rinc;
  logic [24:0] rm25;
  logic signed [11:0] re;
  logic [31:0] rnd_bits;

  assign a_e8   = req.a[30:23];
  assign b_e8   = req.b[30:23];
  assign a_nan  = (&a_e8) && (|req.a[22:0]);
  assign b_nan  = (&b_e8) && (|req.b[22:0]);
  assign a_inf  = (&a_e8) && !(|req.a[22:0]);
  assign b_inf  = (&b_e8) && !(|req.b[22:0]);
  assign a_zero = (req.a[30:0] == 31'd0);
  assign b_zero = (req.b[30:0] == 31'd0);
  assign a_man  = {|a_e8, req.a[22:0]};
  assign b_man  = {|b_e8, req.b[22:0]};
  assign a_exp  = (a_e8 == 8'd0) ? 8'd1 : a_e8;
  assign b_exp  = (b_e8 == 8'd0) ? 8'd1 : b_e8;
  assign sx     = req.a[31] ^ req.b[31];
  assign prod   = a_man * b_man;

  // Addition: larger magnitude first, smaller one aligned with a sticky bit.
  assign a_big   = req.a[30:0] >= req.b[30:0];
  assign l_man   = a_big ? a_man : b_man;
  assign s_man   = a_big ? b_man : a_man;
  assign l_exp   = a_big ? a_exp : b_exp;
  assign s_exp   = a_big ? b_exp : a_exp;
  assign l_sgn   = a_big ? req.a[31] : req.b[31];
  assign dsh     = l_exp - s_exp;
  assign b_full  = {1'b0, s_man, 24'd0};
  assign b_mask  = (49'd1 << dsh) - 49'd1;
  assign b_align = (dsh >= 8'd49) ? 49'd1
                 : ((b_full >> dsh) | {48'd0, |(b_full & b_mask)});
  assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

  // One quotient bit per cycle.
  assign div_diff = {1'b0, rem} - {2'b00, dmb};
  assign div_q    = !div_diff[25];
  assign div_rn   = div_q ? div_diff[24:0] : rem;

  assign den_sh   = 12'sd1 - ex;
  assign den_mask = (49'd1 << den_sh[5:0]) - 49'd1;

  // Rounding and packing.
  assign rm   = mw[48:25];
  assign rs   = stk | (|mw[23:0]);
  assign rinc = mw[24] & (rs | rm[0]);
  assign rm25 = {1'b0, rm} + {24'd0, rinc};
  assign rmf  = rm25[24] ? 24'h80_0000 : rm25[23:0];
  assign re   = rm25[24] ? (ex + 12'sd1) : ex;
  assign rnd_bits = (re >= 12'sd255) ? {sgn, 8'hFF, 23'd0}
                  : {sgn, (rmf[23] ? re[7:0] : 8'd0), rmf[22:0]};

  always_comb begin
    spec_hit  = 1'b0;
    spec_bits = '0;
    unique case (req.op)
      FOP_MUL: begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
          spec_hit = 1'b1; spec_bits = QNAN_BITS;
        end else if (a_inf || b_inf) begin
          spec_hit = 1'b1; spec_bits = {sx, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
          spec_hit = 1'b1; spec_bits = {sx, 31'd0};
        end
      end
      FOP_ADD: begin
        if (a_nan || b_nan || (a_inf && b_inf && (req.a[31] != req.b[31]))) begin
          spec_hit = 1'b1; spec_bits = QNAN_BITS;
        end else if (a_inf) begin
          spec_hit = 1'b1; spec_bits = req.a;
        end else if (b_inf) begin
          spec_hit = 1'b1; spec_bits = req.b;
        end else if (a_zero && b_zero) begin
          spec_hit = 1'b1; spec_bits = {req.a[31] & req.b[31], 31'd0};
        end else if (a_zero) begin
          spec_hit = 1'b1; spec_bits = req.b;
        end else if (b_zero) begin
          spec_hit = 1'b1; spec_bits = req.a;
        end
      end
      FOP_DIV: begin
        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
          spec_hit = 1'b1; spec_bits = QNAN_BITS;
        end else if (a_inf || b_zero) begin
          spec_hit = 1'b1; spec_bits = {sx, 8'hFF, 23'd0};
        end else if (a_zero || b_inf) begin
          spec_hit = 1'b1; spec_bits = {sx, 31'd0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (req.start && !spec_hit) begin
          unique case (req.op)
            FOP_ADD: state_next = F_ADD;
            FOP_MUL: state_next = F_NORM;
            FOP_DIV: state_next = F_DIVNORM;
            default: state_next = F_IDLE;
          endcase
        end
      end
      F_ADD:     state_next = (add_res == 49'd0) ? F_IDLE : F_NORM;
      F_DIVNORM: if (dma[23] && dmb[23]) state_next = F_DIVSTEP;
      F_DIVSTEP: if (cnt == 6'd47) state_next = F_NORM;
      F_NORM:    if (mw[48]) state_next = F_DEN;
      F_DEN:     state_next = F_RND;
      F_RND:     state_next = F_IDLE;
      default:   state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (req.start) begin
            stk <= 1'b0;
            if (spec_hit) begin
              res  <= spec_bits;
              done <= 1'b1;
            end else begin
              unique case (req.op)
                FOP_MUL: begin
                  sgn <= sx;
                  mw  <= {1'b0, prod};
                  ex  <= $signed({4'd0, a_exp}) + $signed({4'd0, b_exp}) - 12'sd125;
                end
                FOP_ADD: begin
                  sgn     <= l_sgn;
                  add_a   <= {1'b0, l_man, 24'd0};
                  add_b   <= b_align;
                  add_sub <= req.a[31] ^ req.b[31];
                  ex      <= $signed({4'd0, l_exp}) + 12'sd1;
                end
                FOP_DIV: begin
                  sgn <= sx;
                  dma <= a_man;
                  dmb <= b_man;
                  ex  <= $signed({4'd0, a_exp}) - $signed({4'd0, b_exp}) + 12'sd128;
                end
                default: ;
              endcase
            end
          end
        end
        F_ADD: begin
          mw <= add_res;
          if (add_res == 49'd0) begin
            res  <= 32'd0;
            done <= 1'b1;
          end
        end
        F_DIVNORM: begin
          if (dma[23] && dmb[23]) begin
            rem <= {1'b0, dma};
            cnt <= 6'd0;
            mw  <= 49'd0;
          end else begin
            if (!dma[23]) dma <= {dma[22:0], 1'b0};
            if (!dmb[23]) dmb <= {dmb[22:0], 1'b0};
            ex <= ex - $signed({11'd0, !dma[23]}) + $signed({11'd0, !dmb[23]});
          end
        end
        F_DIVSTEP: begin
          mw  <= {mw[47:0], div_q};
          rem <= {div_rn[23:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd47) stk <= |div_rn;
        end
        F_NORM: begin
          if (!mw[48]) begin
            if (mw[48:41] == 8'd0) begin
              mw <= {mw[40:0], 8'd0};
              ex <= ex - 12'sd8;
            end else begin
              mw <= {mw[47:0], 1'b0};
              ex <= ex - 12'sd1;
            end
          end
        end
        F_DEN: begin
          if (ex < 12'sd1) begin
            ex <= 12'sd1;
            if (den_sh >= 12'sd49) begin
              mw  <= 49'd0;
              stk <= stk | (|mw);
            end else begin
              mw  <= mw >> den_sh[5:0];
              stk <= stk | (|(mw & den_mask));
            end
          end
        end
        F_RND: begin
          res  <= rnd_bits;
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

endmodule

// File: rtl/core/float_power_binomial_series.sv
// Single-precision power a^b by a truncated binomial series on a shared float unit.
// Special inputs skip the series; otherwise TERM_LIMIT-1 series terms are summed per pass
// (one or two passes), each term a chain of operations on the shared floating-point unit,
// whose divider is radix-2.
// Throughput: one item at a time; the input is ready only while the sequencer is idle.
// Reset: synchronous, active high; clears the sequencer, the float unit and the output.
module float_power_binomial_series (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] base_bits, [63:32] exponent_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] power_bits, [32] domain_error, [39:33] zero
);
  import fpbs_pkg::*;

  seq_state_t state, state_next;
  phase_t     phase;

  logic [31:0]      a_w;        // working base, halved as needed
  logic [31:0]      b_w;        // working exponent, scaled for the second pass
  logic [31:0]      tb;         // exponent truncated toward zero
  logic [31:0]      frac;
  logic             neg;
  logic             err;
  logic [31:0]      result;
  logic [31:0]      series_sum;
  logic [31:0]      power_term;
  logic [31:0]      binomial_term;
  logic [31:0]      t_val;
  logic [31:0]      x_val;
  logic [31:0]      partial_product;
  logic [IDX_W-1:0] term_index;
  logic [7:0]       halving_count;
  logic             issued;

  logic        out_valid;
  logic [31:0] out_bits;
  logic        out_err;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  // Class of the latched operands.
  logic        a_special, b_special, a_zero, b_pos;
  logic [7:0]  be;
  logic [4:0]  tsh;
  logic [23:0] bm;
  logic [31:0] tmask, tb_c;
  logic        odd_c;
  logic [31:0] fi;
  logic        last_term;
  logic        frac_bad;
  logic [31:0] signed_r, final_bits;
  logic        is_fop;

  // Exact conversion of a small nonzero unsigned integer to single precision.
  function automatic logic [31:0] u2f(input logic [10:0] v);
    logic [3:0]  p;
    logic [23:0] m;
    p = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (v[i]) p = 4'(i);
    end
    m = {13'd0, v} << (5'd23 - {1'b0, p});
    return {1'b0, 8'd127 + {4'd0, p}, m[22:0]};
  endfunction

  assign a_special = &a_w[30:23];
  assign b_special = &b_w[30:23];
  assign a_zero    = (a_w[30:0] == 31'd0);
  assign b_pos     = !b_w[31] && (b_w[30:0] != 31'd0);

  // Truncation of the exponent toward zero and the parity of the integer part.
  assign be    = b_w[30:23];
  assign bm    = {1'b1, b_w[22:0]};
  assign tsh   = 5'(8'd150 - be);
  assign tmask = (32'd1 << tsh) - 32'd1;
  always_comb begin
    odd_c = 1'b0;
    tb_c  = b_w;
    if (be < 8'd127) begin
      tb_c = {b_w[31], 31'd0};
    end else if (be <= 8'd150) begin
      odd_c = bm[tsh];
      tb_c  = b_w & ~tmask;
    end
  end

  assign fi        = u2f(11'(term_index));
  assign last_term = (term_index == IDX_W'(TERM_LIMIT - 1));
  // A positive fractional part inside the band, bounds included, marks a non-integral exponent.
  assign frac_bad  = !frac[31] && (frac >= FRAC_LO_BITS) && (frac <= FRAC_HI_BITS);

  assign signed_r   = result ^ {neg, 31'd0};
  assign final_bits = err ? ERROR_BITS
                    : (((&signed_r[30:23]) && (|signed_r[22:0])) ? QNAN_BITS : signed_r);

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CLASS;
      S_CLASS: begin
        if (a_special || b_special || a_zero) state_next = S_DONE;
        else if (a_w[31])                     state_next = S_FRAC;
        else                                  state_next = S_RANGE;
      end
      S_FRAC:  if (fpu_rsp.done) state_next = S_CHECK;
      S_CHECK: state_next = frac_bad ? S_DONE : S_RANGE;
      S_RANGE: if (a_w[30:0] <= TWO_BITS[30:0]) state_next = S_SUB1;
      S_SUB1:  if (fpu_rsp.done) state_next = S_PW;
      S_PW:    if (fpu_rsp.done) state_next = S_BSUB;
      S_BSUB:  if (fpu_rsp.done) state_next = S_BADD;
      S_BADD:  if (fpu_rsp.done) state_next = S_BMUL;
      S_BMUL:  if (fpu_rsp.done) state_next = S_BDIV;
      S_BDIV:  if (fpu_rsp.done) state_next = S_PROD;
      S_PROD:  if (fpu_rsp.done) state_next = S_SUM;
      S_SUM: begin
        if (fpu_rsp.done) begin
          if (!last_term)               state_next = S_PW;
          else if (phase == PH_FIRST)   state_next = S_SCALE;
          else if (phase == PH_SECOND)  state_next = S_FINAL;
          else                          state_next = S_DONE;
        end
      end
      S_SCALE: if (fpu_rsp.done) state_next = S_SUB1;
      S_FINAL: if (fpu_rsp.done) state_next = S_DONE;
      S_DONE:  if (!out_valid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Requests to the float unit, one per operation state.
  always_comb begin
    fpu_req.op = FOP_ADD;
    fpu_req.a  = 32'd0;
    fpu_req.b  = 32'd0;
    is_fop     = 1'b1;
    unique case (state)
      S_FRAC:  begin fpu_req.a = b_w;        fpu_req.b = {~tb[31], tb[30:0]}; end
      S_SUB1:  begin fpu_req.a = a_w;        fpu_req.b = NEG_ONE_BITS; end
      S_PW:    begin fpu_req.op = FOP_MUL; fpu_req.a = power_term; fpu_req.b = t_val; end
      S_BSUB:  begin fpu_req.a = b_w;        fpu_req.b = {1'b1, fi[30:0]}; end
      S_BADD:  begin fpu_req.a = x_val;      fpu_req.b = ONE_BITS; end
      S_BMUL:  begin
        fpu_req.op = FOP_MUL; fpu_req.a = binomial_term; fpu_req.b = x_val;
      end
      S_BDIV:  begin fpu_req.op = FOP_DIV; fpu_req.a = x_val; fpu_req.b = fi; end
      S_PROD:  begin
        fpu_req.op = FOP_MUL; fpu_req.a = power_term; fpu_req.b = binomial_term;
      end
      S_SUM:   begin fpu_req.a = series_sum; fpu_req.b = x_val; end
      S_SCALE: begin
        fpu_req.op = FOP_MUL; fpu_req.a = b_w; fpu_req.b = u2f(11'(halving_count));
      end
      S_FINAL: begin
        fpu_req.op = FOP_MUL; fpu_req.a = partial_product; fpu_req.b = series_sum;
      end
      default: is_fop = 1'b0;
    endcase
    fpu_req.start = is_fop && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fpu_req.start)     issued <= 1'b1;
      else if (fpu_rsp.done) issued <= 1'b0;
      if (out_valid && m_tready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            a_w           <= s_tdata[31:0];
            b_w           <= s_tdata[63:32];
            err           <= 1'b0;
            neg           <= 1'b0;
            result        <= 32'd0;
            halving_count <= 8'd0;
          end
        end
        S_CLASS: begin
          if (a_special || b_special) begin
            err <= 1'b1;
          end else if (a_zero) begin
            err <= !b_pos;
          end else begin
            tb     <= tb_c;
            neg    <= a_w[31] & odd_c;
            a_w[31] <= 1'b0;
          end
        end
        S_FRAC:  if (fpu_rsp.done) frac <= fpu_rsp.result;
        S_CHECK: err <= frac_bad;
        S_RANGE: begin
          if (a_w[30:0] > TWO_BITS[30:0]) begin
            a_w           <= a_w - EXP_LSB_BITS;
            halving_count <= halving_count + 8'd1;
          end else begin
            phase <= (halving_count != 8'd0) ? PH_FIRST : PH_SINGLE;
          end
        end
        S_SUB1: begin
          if (fpu_rsp.done) begin
            t_val         <= fpu_rsp.result;
            series_sum    <= ONE_BITS;
            power_term    <= ONE_BITS;
            binomial_term <= ONE_BITS;
            term_index    <= IDX_W'(1);
          end
        end
        S_PW:   if (fpu_rsp.done) power_term <= fpu_rsp.result;
        S_BSUB: if (fpu_rsp.done) x_val <= fpu_rsp.result;
        S_BADD: if (fpu_rsp.done) x_val <= fpu_rsp.result;
        S_BMUL: if (fpu_rsp.done) x_val <= fpu_rsp.result;
        S_BDIV: if (fpu_rsp.done) binomial_term <= fpu_rsp.result;
        S_PROD: if (fpu_rsp.done) x_val <= fpu_rsp.result;
        S_SUM: begin
          if (fpu_rsp.done) begin
            series_sum <= fpu_rsp.result;
            if (!last_term) begin
              term_index <= term_index + IDX_W'(1);
            end else if (phase == PH_FIRST) begin
              partial_product <= fpu_rsp.result;
              phase           <= PH_SECOND;
            end else if (phase == PH_SINGLE) begin
              result <= fpu_rsp.result;
            end
          end
        end
        S_SCALE: begin
          if (fpu_rsp.done) begin
            b_w <= fpu_rsp.result;
            a_w <= TWO_BITS;
          end
        end
        S_FINAL: if (fpu_rsp.done) result <= fpu_rsp.result;
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_bits  <= final_bits;
            out_err   <= err;
          end
        end
        default: ;
      endcase
    end
  end

  fpbs_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_err, out_bits};

  // The float unit only answers a request that the sequencer is waiting on.
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    fpu_rsp.done |-> issued)
    else $error("float unit answered without a pending request");

  // An accepted item is classified in the next cycle.
  a_accept_class: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CLASS))
    else $error("accepted item not classified");

  // A flagged result always carries the error pattern.
  a_err_bits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == ERROR_BITS))
    else $error("domain error without error pattern");

  // The term counter never runs past the last term.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PW) |-> (term_index <= IDX_W'(TERM_LIMIT - 1)))
    else $error("term index out of range");

endmodule
